// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the token dictionary RTL.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define AST_ALWAYS(lbl, ck, rst_n, expr, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (expr)) else $error(msg);
`define AST_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define AST_ALWAYS(lbl, ck, rst_n, expr, msg)
`define AST_NEXT(lbl, ck, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/tdh_pkg.sv =====
// Constants, status codes and the djb2 step for the token dictionary.
// No dependencies.
package tdh_pkg;
	localparam int MAX_ENTRIES   = 1024;
	localparam int BUCKETS       = 4096;
	localparam int MAX_TOKEN_LEN = 32;
	localparam int BKT_W  = $clog2(BUCKETS);
	localparam int LEN_W  = $clog2(MAX_TOKEN_LEN);
	localparam int LCNT_W = $clog2(MAX_TOKEN_LEN + 1);
	localparam int HASH_W = 32;
	localparam int ID_W   = 11;
	localparam int CFG_W  = 10;
	localparam int STAT_W = 3;

	localparam logic [HASH_W-1:0] HASH_INIT      = 32'd5381;
	localparam logic [CFG_W-1:0]  FIRST_ID_RESET = 10'd10;

	localparam logic [STAT_W-1:0] ST_FOUND     = 3'd0;
	localparam logic [STAT_W-1:0] ST_ADDED     = 3'd1;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
	localparam logic [STAT_W-1:0] ST_TOO_LONG  = 3'd4;

	function automatic logic [HASH_W-1:0] djb2_step(input logic [HASH_W-1:0] h,
		input logic [7:0] b);
		return (h << 5) + h + {24'd0, b};
	endfunction
endpackage

// ===== rtl/tdh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tdh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== rtl/token_dictionary_hash_lookup.sv =====
// Token dictionary: djb2 chained hash table with find and add.
// Uses tdh_pkg, tdh_ram and assert_macros.svh.
//
//   channel | signals                          | direction
//   in      | in_valid in_stall mode token_byte last_byte | beat in
//   out     | out_valid out_stall status lookup_id | beat out
//   cfg     | cfg_wr_en cfg_wr_data (first_token_id) | write only
//
// Bytes are taken while in_stall is low. A last byte starts the lookup, which
// reads the bucket head and walks the chain, comparing each entry's length and,
// on a length match, its bytes; on an add it copies the token bytes into the new
// entry. An overlong token goes straight to its result. The single memory read
// port of each store paces the walk. After reset a clearing pass empties the
// bucket heads while in_stall is high. A stalled result holds the block at its
// end of lookup only while the output register is full; the next token may
// start while a result waits there.
`include "assert_macros.svh"
module token_dictionary_hash_lookup #(
	parameter int MAX_ENTRIES = tdh_pkg::MAX_ENTRIES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [tdh_pkg::CFG_W-1:0]   cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        mode,
	input  logic [7:0]                  token_byte,
	input  logic                        last_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [tdh_pkg::STAT_W-1:0]  status,
	output logic [tdh_pkg::ID_W-1:0]    lookup_id
);
	localparam int SLOT_W  = $clog2(MAX_ENTRIES);
	localparam int LINK_W  = $clog2(MAX_ENTRIES + 1);
	localparam int BYTE_AW = SLOT_W + tdh_pkg::LEN_W;
	localparam int LEN_W   = tdh_pkg::LEN_W;
	localparam int LCNT_W  = tdh_pkg::LCNT_W;
	localparam int BKT_W   = tdh_pkg::BKT_W;
	localparam int ID_W    = tdh_pkg::ID_W;

	typedef enum logic [11:0] {
		S_CLR  = 12'b0000_0000_0001,
		S_IDLE = 12'b0000_0000_0010,
		S_HEAD = 12'b0000_0000_0100,
		S_LINK = 12'b0000_0000_1000,
		S_WALK = 12'b0000_0001_0000,
		S_LEN  = 12'b0000_0010_0000,
		S_BRD  = 12'b0000_0100_0000,
		S_BCMP = 12'b0000_1000_0000,
		S_MISS = 12'b0001_0000_0000,
		S_CRD  = 12'b0010_0000_0000,
		S_CWR  = 12'b0100_0000_0000,
		S_RES  = 12'b1000_0000_0000
	} state_t;

	state_t                        state_q;
	logic [tdh_pkg::CFG_W-1:0]     first_id_q;
	logic [tdh_pkg::HASH_W-1:0]    hash_q;
	logic [LCNT_W-1:0]             len_q;
	logic                          long_q;
	logic [BKT_W-1:0]              bucket_q;
	logic                          mode_q;
	logic [LINK_W-1:0]             head_q;
	logic [LINK_W-1:0]             link_q;
	logic [LINK_W-1:0]             next_q;
	logic [LEN_W-1:0]              idx_q;
	logic [LINK_W-1:0]             count_q;
	logic [BKT_W-1:0]              clr_q;
	logic [tdh_pkg::STAT_W-1:0]    res_status_q;
	logic [ID_W-1:0]               res_id_q;
	logic                          out_valid_q;
	logic [tdh_pkg::STAT_W-1:0]    status_q;
	logic [ID_W-1:0]               lookup_id_q;

	logic                          in_accept;
	logic                          out_load;
	logic                          res_fire;
	logic                          add_fire;
	logic [LINK_W-1:0]             cnt_inc;
	logic [tdh_pkg::HASH_W-1:0]    hash_nx;
	logic                          len_full;
	logic                          long_nx;
	logic [LINK_W-1:0]             link_dec;
	logic [SLOT_W-1:0]             slot_cur;
	logic [SLOT_W-1:0]             slot_new;
	logic [LCNT_W-1:0]             len_dec;
	logic                          last_idx;
	logic                          link_ok;
	logic                          add_ok;
	logic [ID_W-1:0]               id_cur;
	logic [ID_W-1:0]               id_new;

	logic                          head_we;
	logic [BKT_W-1:0]              head_waddr;
	logic [LINK_W-1:0]             head_wdata;
	logic [LINK_W-1:0]             head_rd;
	logic [LINK_W-1:0]             next_rd;
	logic [LCNT_W-1:0]             len_rd;
	logic [7:0]                    tok_rd;
	logic [7:0]                    byte_rd;
	logic                          entry_we;

	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid & ~in_stall;
	assign out_load  = ~out_valid_q | ~out_stall;
	assign res_fire  = (state_q == S_RES) && out_load;
	assign add_fire  = res_fire && (res_status_q == tdh_pkg::ST_ADDED);
	assign cnt_inc   = count_q + LINK_W'(1);
	assign hash_nx   = tdh_pkg::djb2_step(hash_q, token_byte);
	assign len_full  = (len_q == LCNT_W'(tdh_pkg::MAX_TOKEN_LEN));
	assign long_nx   = long_q | len_full;
	assign link_dec  = link_q - LINK_W'(1);
	assign slot_cur  = link_dec[SLOT_W-1:0];
	assign slot_new  = count_q[SLOT_W-1:0];
	assign len_dec   = len_q - LCNT_W'(1);
	assign last_idx  = (idx_q == len_dec[LEN_W-1:0]);
	assign link_ok   = (link_q != '0) && (link_q <= LINK_W'(MAX_ENTRIES));
	assign add_ok    = mode_q && (count_q < LINK_W'(MAX_ENTRIES));
	assign id_cur    = ID_W'(first_id_q) + ID_W'(slot_cur);
	assign id_new    = ID_W'(first_id_q) + ID_W'(slot_new);
	assign entry_we  = (state_q == S_MISS) && add_ok;

	assign head_we    = (state_q == S_CLR) || entry_we;
	assign head_waddr = (state_q == S_CLR) ? clr_q : bucket_q;
	assign head_wdata = (state_q == S_CLR) ? '0 : cnt_inc;

	tdh_ram #(.WIDTH(8), .DEPTH(tdh_pkg::MAX_TOKEN_LEN)) u_tok_ram (
		.clk   (clk),
		.we    (in_accept & ~len_full),
		.waddr (len_q[LEN_W-1:0]),
		.wdata (token_byte),
		.raddr (idx_q),
		.rdata (tok_rd)
	);

	tdh_ram #(.WIDTH(LINK_W), .DEPTH(tdh_pkg::BUCKETS)) u_head_ram (
		.clk   (clk),
		.we    (head_we),
		.waddr (head_waddr),
		.wdata (head_wdata),
		.raddr (bucket_q),
		.rdata (head_rd)
	);

	tdh_ram #(.WIDTH(LINK_W), .DEPTH(MAX_ENTRIES)) u_next_ram (
		.clk   (clk),
		.we    (entry_we),
		.waddr (slot_new),
		.wdata (head_q),
		.raddr (slot_cur),
		.rdata (next_rd)
	);

	tdh_ram #(.WIDTH(LCNT_W), .DEPTH(MAX_ENTRIES)) u_len_ram (
		.clk   (clk),
		.we    (entry_we),
		.waddr (slot_new),
		.wdata (len_q),
		.raddr (slot_cur),
		.rdata (len_rd)
	);

	tdh_ram #(.WIDTH(8), .DEPTH(MAX_ENTRIES * tdh_pkg::MAX_TOKEN_LEN)) u_byte_ram (
		.clk   (clk),
		.we    (state_q == S_CWR),
		.waddr ({slot_new, idx_q}),
		.wdata (tok_rd),
		.raddr ({slot_cur, idx_q}),
		.rdata (byte_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			first_id_q  <= tdh_pkg::FIRST_ID_RESET;
			hash_q      <= tdh_pkg::HASH_INIT;
			len_q       <= '0;
			long_q      <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				first_id_q <= cfg_wr_data;
			end
			if (out_valid_q && !out_stall && state_q != S_RES) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + BKT_W'(1);
					if (clr_q == BKT_W'(tdh_pkg::BUCKETS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_accept) begin
						if (!len_full) begin
							len_q <= len_q + LCNT_W'(1);
						end else begin
							long_q <= 1'b1;
						end
						if (last_byte) begin
							hash_q   <= tdh_pkg::HASH_INIT;
							bucket_q <= hash_nx[BKT_W-1:0];
							mode_q   <= mode;
							if (long_nx) begin
								res_status_q <= tdh_pkg::ST_TOO_LONG;
								res_id_q     <= '0;
								state_q      <= S_RES;
							end else begin
								state_q <= S_HEAD;
							end
						end else begin
							hash_q <= hash_nx;
						end
					end
				end
				S_HEAD: begin
					state_q <= S_LINK;
				end
				S_LINK: begin
					head_q  <= head_rd;
					link_q  <= head_rd;
					state_q <= S_WALK;
				end
				S_WALK: begin
					state_q <= link_ok ? S_LEN : S_MISS;
				end
				S_LEN: begin
					next_q <= next_rd;
					if (len_rd == len_q) begin
						idx_q   <= '0;
						state_q <= S_BRD;
					end else begin
						link_q  <= next_rd;
						state_q <= S_WALK;
					end
				end
				S_BRD: begin
					state_q <= S_BCMP;
				end
				S_BCMP: begin
					if (tok_rd != byte_rd) begin
						link_q  <= next_q;
						state_q <= S_WALK;
					end else if (last_idx) begin
						res_status_q <= tdh_pkg::ST_FOUND;
						res_id_q     <= id_cur;
						state_q      <= S_RES;
					end else begin
						idx_q   <= idx_q + LEN_W'(1);
						state_q <= S_BRD;
					end
				end
				S_MISS: begin
					res_id_q <= '0;
					if (!mode_q) begin
						res_status_q <= tdh_pkg::ST_NOT_FOUND;
						state_q      <= S_RES;
					end else if (!add_ok) begin
						res_status_q <= tdh_pkg::ST_FULL;
						state_q      <= S_RES;
					end else begin
						idx_q   <= '0;
						state_q <= S_CRD;
					end
				end
				S_CRD: begin
					state_q <= S_CWR;
				end
				S_CWR: begin
					if (last_idx) begin
						res_status_q <= tdh_pkg::ST_ADDED;
						res_id_q     <= id_new;
						state_q      <= S_RES;
					end else begin
						idx_q   <= idx_q + LEN_W'(1);
						state_q <= S_CRD;
					end
				end
				S_RES: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						status_q    <= res_status_q;
						lookup_id_q <= res_id_q;
						len_q       <= '0;
						long_q      <= 1'b0;
						if (res_status_q == tdh_pkg::ST_ADDED) begin
							count_q <= cnt_inc;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign lookup_id = lookup_id_q;

	`AST_ALWAYS(a_count_bound, clk, arst_n, count_q <= LINK_W'(MAX_ENTRIES), "count overflow")
	`AST_NEXT(a_add_count, clk, arst_n, add_fire, count_q == $past(cnt_inc), "count stuck")
	`AST_NEXT(a_out_from_res, clk, arst_n, !out_valid_q, !out_valid_q || $past(res_fire), "stray beat")
	`AST_ALWAYS(a_no_out_in_clear, clk, arst_n, state_q != S_CLR || !out_valid_q, "beat in clear")
endmodule
